FILE: rtl/nearest_block_selection_macros.svh
// ----------------------------------------------------------------------------
// nearest_block_selection_macros.svh
// Assertion helpers shared by the nearest block selection modules. Each macro
// expects the enclosing module to provide clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef NEAREST_BLOCK_SELECTION_MACROS_SVH
`define NEAREST_BLOCK_SELECTION_MACROS_SVH

// Same-cycle implication, disabled during reset
`define NBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define NBS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/nbs_pkg.sv
// ----------------------------------------------------------------------------
// nbs_pkg
// Shared constants, codes and types for the nearest block selection block.
// ----------------------------------------------------------------------------
package nbs_pkg;

    // Default sizes
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int MAX_SELECT_DEF  = 8;

    // Fixed field widths
    localparam int COORD_W   = 24;
    localparam int RADIUS_W  = 23;
    localparam int IDX_IN_W  = 6;
    localparam int BIDX_W    = 7;
    localparam int SLOT_W    = 3;
    localparam int COUNT_W   = 4;
    localparam int BCOUNT_W  = 7;
    localparam int SLIMIT_W  = 4;
    localparam int DIST_W    = 50;

    // Operation codes carried in tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_BLOCK_COUNT  = 1'b0;
    localparam logic REG_SELECT_LIMIT = 1'b1;

    // Reset values and empty slot marker
    localparam logic [BCOUNT_W-1:0] BLOCK_COUNT_RST  = 7'd0;
    localparam logic [SLIMIT_W-1:0] SELECT_LIMIT_RST = 4'd8;
    localparam logic [BIDX_W-1:0]   EMPTY_INDEX      = 7'h7F;

    // Commands from controller to datapath
    typedef struct packed {
        logic wr_en;    // write table entry from input beat
        logic q_start;  // latch origin, clear selection list
        logic rd_en;    // read one table entry into the pipeline
    } nbs_cmd_t;

    // One table entry
    typedef struct packed {
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cy;
        logic [COORD_W-1:0]  cz;
        logic [RADIUS_W-1:0] r;
    } nbs_entry_t;

endpackage

FILE: rtl/nbs_ctrl.sv
// ----------------------------------------------------------------------------
// nbs_ctrl
// Controller: accepts input beats, sequences the table scan, waits for the
// distance pipeline to drain and steps through the result slots.
// ----------------------------------------------------------------------------
`include "nearest_block_selection_macros.svh"

module nbs_ctrl
    import nbs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int MAX_SELECT  = MAX_SELECT_DEF,
    parameter int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    parameter int CW  = $clog2(MAX_SELECT + 1),
    parameter int SW  = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    input  logic                s_op,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_last,
    input  logic [BCOUNT_W-1:0] block_count,
    input  logic [SLIMIT_W-1:0] select_limit,
    input  logic                busy,
    output nbs_cmd_t            cmd,
    output logic [AW-1:0]       rd_addr,
    output logic [CW-1:0]       limit,
    output logic [SW-1:0]       emit_slot
);

    localparam int SCW = $clog2(MAX_ENTRIES + 1);
    localparam int MW  = (SCW > BCOUNT_W) ? SCW : BCOUNT_W;
    localparam int LW  = (CW > SLIMIT_W) ? CW : SLIMIT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [SCW-1:0] scan_ctr_reg, scan_ctr_next;
    logic [CW-1:0]  emit_ctr_reg, emit_ctr_next;
    logic [SCW-1:0] scan_len;
    logic [MW-1:0]  bc_w;
    logic [LW-1:0]  sl_w;
    logic           s_fire;
    logic           m_fire;

    // Clamp the configured scan length and slot count
    assign bc_w     = MW'(block_count);
    assign scan_len = (bc_w > MW'(MAX_ENTRIES)) ? SCW'(MAX_ENTRIES) : bc_w[SCW-1:0];
    assign sl_w     = LW'(select_limit);
    always_comb
    begin
        priority if (sl_w == '0)
        begin
            limit = CW'(1);
        end
        else if (sl_w > LW'(MAX_SELECT))
        begin
            limit = CW'(MAX_SELECT);
        end
        else
        begin
            limit = sl_w[CW-1:0];
        end
    end

    // Handshake views
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = (state_reg == ST_EMIT);
    assign m_fire    = m_valid && m_ready;
    assign m_last    = ((emit_ctr_reg + CW'(1)) == limit);
    assign emit_slot = emit_ctr_reg[SW-1:0];
    assign rd_addr   = scan_ctr_reg[AW-1:0];

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        scan_ctr_next = scan_ctr_reg;
        emit_ctr_next = emit_ctr_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_op == OP_QUERY)
                    begin
                        cmd.q_start   = 1'b1;
                        scan_ctr_next = '0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_ctr_reg == scan_len)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.rd_en     = 1'b1;
                    scan_ctr_next = scan_ctr_reg + SCW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!busy)
                begin
                    emit_ctr_next = '0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (m_fire)
                begin
                    if (m_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_ctr_next = emit_ctr_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_ctr_reg <= '0;
            emit_ctr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_ctr_reg <= scan_ctr_next;
            emit_ctr_reg <= emit_ctr_next;
        end
    end

    `NBS_ASSERT_NXT(a_drain_to_emit, (state_reg == ST_DRAIN) && !busy, m_valid, "drain did not lead to emit")
    `NBS_ASSERT_IMP(a_rd_in_range, cmd.rd_en, SCW'(rd_addr) < scan_len, "table read beyond scan length")
    `NBS_ASSERT_NXT(a_last_frees_input, m_fire && m_last, s_ready, "input not free after final result")

endmodule

FILE: rtl/nbs_dpath.sv
// ----------------------------------------------------------------------------
// nbs_dpath
// Datapath: sphere table, squared distance pipeline and the sorted list of
// the nearest candidates.
// ----------------------------------------------------------------------------
`include "nearest_block_selection_macros.svh"

module nbs_dpath
    import nbs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int MAX_SELECT  = MAX_SELECT_DEF,
    parameter int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    parameter int CW  = $clog2(MAX_SELECT + 1),
    parameter int SW  = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  nbs_cmd_t            cmd,
    input  logic [IDX_IN_W-1:0] entry_index,
    input  logic [COORD_W-1:0]  point_x,
    input  logic [COORD_W-1:0]  point_y,
    input  logic [COORD_W-1:0]  point_z,
    input  logic [RADIUS_W-1:0] sphere_radius,
    input  logic [AW-1:0]       rd_addr,
    input  logic [CW-1:0]       limit,
    input  logic [SW-1:0]       emit_slot,
    output logic                busy,
    output logic [BIDX_W-1:0]   block_index,
    output logic [CW-1:0]       found_count
);

    // Table storage, no reset
    nbs_entry_t entry_mem_reg [MAX_ENTRIES];
    nbs_entry_t rd_reg;

    logic [31:0]   wr_idx32;
    logic [AW-1:0] wr_addr;
    logic          wr_ok;

    // Query origin
    logic [COORD_W-1:0] ox_reg, oy_reg, oz_reg;

    // Pipeline valids and indexes
    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic [AW-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;

    // Stage 2: differences
    logic signed [COORD_W:0] dx_reg, dy_reg, dz_reg;
    logic [RADIUS_W-1:0]     r2_reg;

    // Stage 3: squares
    logic signed [2*COORD_W+1:0] px_prod, py_prod, pz_prod;
    logic [2*COORD_W:0]          sqx_reg, sqy_reg, sqz_reg;
    logic [2*RADIUS_W-1:0]       rr_reg;

    // Stage 4: distance and bound
    logic [DIST_W-1:0] d2_reg, lim_reg;

    // Sorted list
    logic [DIST_W-1:0] best_d_reg [MAX_SELECT];
    logic [DIST_W-1:0] best_d_next[MAX_SELECT];
    logic [AW-1:0]     best_i_reg [MAX_SELECT];
    logic [AW-1:0]     best_i_next[MAX_SELECT];
    logic [MAX_SELECT-1:0] lt;
    logic [CW-1:0]     found_reg;
    logic              hit;

    logic [31:0] bi32;

    // Write decode: drop writes beyond the table
    assign wr_idx32 = 32'(entry_index);
    assign wr_addr  = wr_idx32[AW-1:0];
    assign wr_ok    = (wr_idx32 < 32'(MAX_ENTRIES));

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_ok)
        begin
            entry_mem_reg[wr_addr] <= '{cx: point_x, cy: point_y, cz: point_z, r: sphere_radius};
        end
        if (cmd.rd_en)
        begin
            rd_reg <= entry_mem_reg[rd_addr];
        end
    end

    // Latch the origin at query start
    always_ff @(posedge clk)
    begin
        if (cmd.q_start)
        begin
            ox_reg <= point_x;
            oy_reg <= point_y;
            oz_reg <= point_z;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign busy = v1_reg || v2_reg || v3_reg || v4_reg;

    // Multiply the differences; squares are never negative
    assign px_prod = dx_reg * dx_reg;
    assign py_prod = dy_reg * dy_reg;
    assign pz_prod = dz_reg * dz_reg;

    // Distance pipeline payload
    always_ff @(posedge clk)
    begin
        idx1_reg <= rd_addr;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;

        dx_reg <= $signed({ox_reg[COORD_W-1], ox_reg}) - $signed({rd_reg.cx[COORD_W-1], rd_reg.cx});
        dy_reg <= $signed({oy_reg[COORD_W-1], oy_reg}) - $signed({rd_reg.cy[COORD_W-1], rd_reg.cy});
        dz_reg <= $signed({oz_reg[COORD_W-1], oz_reg}) - $signed({rd_reg.cz[COORD_W-1], rd_reg.cz});
        r2_reg <= rd_reg.r;

        sqx_reg <= px_prod[2*COORD_W:0];
        sqy_reg <= py_prod[2*COORD_W:0];
        sqz_reg <= pz_prod[2*COORD_W:0];
        rr_reg  <= r2_reg * r2_reg;

        d2_reg  <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg);
        lim_reg <= DIST_W'({rr_reg, 3'b000}) + DIST_W'(rr_reg);
    end

    // Insert a candidate: later equal distances stay behind earlier ones
    assign hit = v4_reg && (d2_reg <= lim_reg);

    always_comb
    begin
        for (int k = 0; k < MAX_SELECT; k++)
        begin
            lt[k] = (CW'(k) >= found_reg) || (d2_reg < best_d_reg[k]);
        end
        for (int k = 0; k < MAX_SELECT; k++)
        begin
            best_d_next[k] = best_d_reg[k];
            best_i_next[k] = best_i_reg[k];
            if (lt[k])
            begin
                if (k == 0)
                begin
                    best_d_next[k] = d2_reg;
                    best_i_next[k] = idx4_reg;
                end
                else if (!lt[k-1])
                begin
                    best_d_next[k] = d2_reg;
                    best_i_next[k] = idx4_reg;
                end
                else
                begin
                    best_d_next[k] = best_d_reg[k-1];
                    best_i_next[k] = best_i_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            best_d_reg <= best_d_next;
            best_i_reg <= best_i_next;
        end
    end

    // Count the selected blocks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= '0;
        end
        else if (cmd.q_start)
        begin
            found_reg <= '0;
        end
        else if (hit && (found_reg < limit))
        begin
            found_reg <= found_reg + CW'(1);
        end
    end

    // Result slot selection
    assign bi32        = 32'(best_i_reg[emit_slot]);
    assign block_index = (CW'(emit_slot) < found_reg) ? bi32[BIDX_W-1:0] : EMPTY_INDEX;
    assign found_count = found_reg;

    `NBS_ASSERT_NXT(a_found_capped, v4_reg, found_reg <= limit, "selected count above limit")

endmodule

FILE: rtl/nearest_block_selection.sv
// ----------------------------------------------------------------------------
// nearest_block_selection
// Table of spheres with a radius filtered nearest-entry query.
//   Input beats arrive on s_tvalid/s_tready with the operation on s_tuser: a
//   write beat stores one sphere at entry_index and gives no result; a query
//   beat carries an origin and returns one result beat per slot on
//   m_tvalid/m_tready (select_limit slots, 0 counts as 1, above 8 as 8),
//   nearest first, ties to the lower index, empty slots as index -1,
//   m_tlast on the final beat. Registers: block_count at 0x0, select_limit 0x4.
//   A query is accepted, then the scan makes one table read a cycle
//   (block_count entries, clamped to 64), the distance pipeline drains and
//   the result beats follow, one a cycle while m_tready is high. One item
//   is handled at a time; s_tready is low from query accept until the last
//   result beat. A stalled receiver holds the current beat on m_tdata and
//   pauses the run. Reset clears the control logic and the registers
//   (block_count 0, select_limit 8); table contents are undefined until
//   written.
// ----------------------------------------------------------------------------
module nearest_block_selection
    import nbs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int MAX_SELECT  = MAX_SELECT_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // entry_index, point_x, point_y, point_z, sphere_radius
    input  logic         s_tuser,  // op
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,  // block_index, slot, selected_count
    output logic         m_tlast,
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_SELECT + 1);
    localparam int SW = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;

    logic [BCOUNT_W-1:0] block_count_reg;
    logic [SLIMIT_W-1:0] select_limit_reg;
    logic                cfg_wr;

    nbs_cmd_t            cmd;
    logic [AW-1:0]       rd_addr;
    logic [CW-1:0]       limit;
    logic [SW-1:0]       emit_slot;
    logic                busy;
    logic [BIDX_W-1:0]   block_index;
    logic [CW-1:0]       found_count;
    logic [31:0]         slot32;
    logic [31:0]         count32;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg  <= BLOCK_COUNT_RST;
            select_limit_reg <= SELECT_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_BLOCK_COUNT:  block_count_reg  <= pwdata[BCOUNT_W-1:0];
                REG_SELECT_LIMIT: select_limit_reg <= pwdata[SLIMIT_W-1:0];
                default:          block_count_reg  <= block_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_BLOCK_COUNT:  prdata = 32'(block_count_reg);
            REG_SELECT_LIMIT: prdata = 32'(select_limit_reg);
            default:          prdata = '0;
        endcase
    end

    // Sequencing
    nbs_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_SELECT  (MAX_SELECT),
        .AW          (AW),
        .CW          (CW),
        .SW          (SW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_valid      (s_tvalid),
        .s_op         (s_tuser),
        .s_ready      (s_tready),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_last       (m_tlast),
        .block_count  (block_count_reg),
        .select_limit (select_limit_reg),
        .busy         (busy),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .limit        (limit),
        .emit_slot    (emit_slot)
    );

    // Table, distances and selection list
    nbs_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_SELECT  (MAX_SELECT),
        .AW          (AW),
        .CW          (CW),
        .SW          (SW)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .entry_index   (s_tdata[5:0]),
        .point_x       (s_tdata[29:6]),
        .point_y       (s_tdata[53:30]),
        .point_z       (s_tdata[77:54]),
        .sphere_radius (s_tdata[100:78]),
        .rd_addr       (rd_addr),
        .limit         (limit),
        .emit_slot     (emit_slot),
        .busy          (busy),
        .block_index   (block_index),
        .found_count   (found_count)
    );

    // Pack the result beat
    assign slot32  = 32'(emit_slot);
    assign count32 = 32'(found_count);
    assign m_tdata = {2'b00, count32[COUNT_W-1:0], slot32[SLOT_W-1:0], block_index};

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level check of nearest_block_selection. A shadow sphere table and
// its own nearest-first selection predict every result beat of a query;
// result beats are compared in order against the queue of predicted results.
// A short table of directed items opens the run, then the table is filled and
// random phases follow under several register settings and handshake loads.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nbs_pkg::*;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_REPORTS   = 10;
    localparam int N_PHASES      = 8;

    localparam logic signed [COORD_W-1:0] ONE     = 24'sd4096;
    localparam logic signed [COORD_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] NEG_MIN = 24'sh800000;
    localparam logic [RADIUS_W-1:0]       R_MAX   = 23'h7FFFFF;

    typedef struct packed {
        logic [BIDX_W-1:0]  block_index;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] sel_count;
        logic               last;
    } result_t;

    typedef enum logic {ROW_ITEM, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic                      op;
        logic [IDX_IN_W-1:0]       idx;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic [RADIUS_W-1:0]       rad;
        bit                        typed;
        int                        t_count;
        logic [BIDX_W-1:0]         t_first;
        logic [BCOUNT_W-1:0]       bc;
        logic [SLIMIT_W-1:0]       sl;
    } row_t;

    typedef struct {
        int bc;
        int sl;
        int tx_idle;
        int rx_stall;
        int count;
        bit squeeze;
    } phase_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;   // entry_index, point_x, point_y, point_z, sphere_radius
    logic         s_tuser;   // op
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;   // block_index, slot, selected_count
    logic         m_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // Shadow of the sphere table and the registers
    logic signed [COORD_W-1:0] sph_x [MAX_ENTRIES_DEF];
    logic signed [COORD_W-1:0] sph_y [MAX_ENTRIES_DEF];
    logic signed [COORD_W-1:0] sph_z [MAX_ENTRIES_DEF];
    logic [RADIUS_W-1:0]       sph_r [MAX_ENTRIES_DEF];
    logic [BCOUNT_W-1:0]       cur_block_count = BLOCK_COUNT_RST;
    logic [SLIMIT_W-1:0]       cur_select_limit = SELECT_LIMIT_RST;

    result_t pending_results[$];
    int      errors = 0;
    int      cycle_count = 0;
    int      tx_idle_pct = 0;
    int      rx_stall_pct = 0;
    bit      long_hold_req = 1'b0;

    nearest_block_selection dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result slots per query: zero counts as one, large values saturate
    function automatic int slots_per_query();
        if (cur_select_limit == 0)
            return 1;
        if (cur_select_limit > MAX_SELECT_DEF)
            return MAX_SELECT_DEF;
        return int'(cur_select_limit);
    endfunction

    // Append one predicted result beat
    function automatic void queue_result(result_t res);
        pending_results.insert(pending_results.size(), res);
    endfunction

    function automatic longint sq_gap(logic signed [COORD_W-1:0] a,
                                      logic signed [COORD_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return d * d;
    endfunction

    // Pick the nearest spheres within three radii and queue their beats
    function automatic void select_nearest(logic signed [COORD_W-1:0] ox,
                                           logic signed [COORD_W-1:0] oy,
                                           logic signed [COORD_W-1:0] oz);
        longint  near_d [MAX_SELECT_DEF];
        int      near_i [MAX_SELECT_DEF];
        int      lim;
        int      span;
        int      found;
        int      pos;
        int      k;
        longint  d2;
        longint  reach;
        result_t res;
        lim   = slots_per_query();
        span  = (cur_block_count > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF
                                                    : int'(cur_block_count);
        found = 0;
        for (int j = 0; j < span; j++)
        begin
            d2    = sq_gap(ox, sph_x[j]) + sq_gap(oy, sph_y[j]) + sq_gap(oz, sph_z[j]);
            reach = 9 * longint'(sph_r[j]) * longint'(sph_r[j]);
            if (d2 <= reach)
            begin
                // strictly nearer only, so equal distances keep index order
                pos = found;
                while (pos > 0 && d2 < near_d[pos-1])
                    pos--;
                if (pos < lim)
                begin
                    k = (found < lim) ? found : lim - 1;
                    while (k > pos)
                    begin
                        near_d[k] = near_d[k-1];
                        near_i[k] = near_i[k-1];
                        k--;
                    end
                    near_d[pos] = d2;
                    near_i[pos] = j;
                    if (found < lim)
                        found++;
                end
            end
        end
        for (k = 0; k < lim; k++)
        begin
            res.block_index = (k < found) ? BIDX_W'(near_i[k]) : EMPTY_INDEX;
            res.slot        = SLOT_W'(k);
            res.sel_count   = COUNT_W'(found);
            res.last        = (k == lim - 1);
            queue_result(res);
        end
    endfunction

    // Queue a hand-written run: count hits, the first at index first
    function automatic void push_typed(int count, logic [BIDX_W-1:0] first);
        result_t res;
        int      lim;
        lim = slots_per_query();
        for (int k = 0; k < lim; k++)
        begin
            res.block_index = (k < count) ? first : EMPTY_INDEX;
            res.slot        = SLOT_W'(k);
            res.sel_count   = COUNT_W'(count);
            res.last        = (k == lim - 1);
            queue_result(res);
        end
    endfunction

    function automatic row_t item_row(logic op, logic [IDX_IN_W-1:0] idx,
                                      logic signed [COORD_W-1:0] x,
                                      logic signed [COORD_W-1:0] y,
                                      logic signed [COORD_W-1:0] z,
                                      logic [RADIUS_W-1:0] r);
        row_t row;
        row.kind    = ROW_ITEM;
        row.op      = op;
        row.idx     = idx;
        row.px      = x;
        row.py      = y;
        row.pz      = z;
        row.rad     = r;
        row.typed   = 1'b0;
        row.t_count = 0;
        row.t_first = EMPTY_INDEX;
        row.bc      = '0;
        row.sl      = '0;
        return row;
    endfunction

    // Query with the run written out by hand; ignored fields are random
    function automatic row_t typed_query(logic signed [COORD_W-1:0] x,
                                         logic signed [COORD_W-1:0] y,
                                         logic signed [COORD_W-1:0] z,
                                         int count, logic [BIDX_W-1:0] first);
        row_t row;
        row = item_row(OP_QUERY, IDX_IN_W'($urandom()), x, y, z, RADIUS_W'($urandom()));
        row.typed   = 1'b1;
        row.t_count = count;
        row.t_first = first;
        return row;
    endfunction

    function automatic row_t query_row(logic signed [COORD_W-1:0] x,
                                       logic signed [COORD_W-1:0] y,
                                       logic signed [COORD_W-1:0] z);
        return item_row(OP_QUERY, IDX_IN_W'($urandom()), x, y, z, RADIUS_W'($urandom()));
    endfunction

    function automatic row_t config_row(int bc, int sl);
        row_t row;
        row      = item_row(OP_WRITE, '0, '0, '0, '0, '0);
        row.kind = ROW_CONFIG;
        row.bc   = BCOUNT_W'(bc);
        row.sl   = SLIMIT_W'(sl);
        return row;
    endfunction

    // Coordinate in a small box round the origin, where spheres overlap
    function automatic logic signed [COORD_W-1:0] near_coord();
        return COORD_W'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic row_t random_row(int write_pct);
        row_t row;
        int   pick;
        int   src;
        row  = item_row(($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_QUERY,
                        IDX_IN_W'($urandom()), '0, '0, '0, RADIUS_W'($urandom()));
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            row.px = near_coord();
            row.py = near_coord();
            row.pz = near_coord();
        end
        else if (pick < 75)
        begin
            // reuse a stored center: zero distances and ties
            src    = $urandom_range(0, MAX_ENTRIES_DEF - 1);
            row.px = sph_x[src];
            row.py = sph_y[src];
            row.pz = sph_z[src];
        end
        else
        begin
            row.px = COORD_W'($urandom());
            row.py = COORD_W'($urandom());
            row.pz = COORD_W'($urandom());
        end
        if (row.op == OP_WRITE)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                row.rad = RADIUS_W'($urandom_range(0, 8192));
            else if (pick < 80)
                row.rad = '0;
            else if (pick < 90)
                row.rad = R_MAX;
        end
        return row;
    endfunction

    // Offer one beat, wait for the handshake, then update the shadow state
    task automatic send_beat(input row_t row);
        int gap;
        gap = 0;
        while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.op;
        s_tdata  <= {3'b000, row.rad, row.pz, row.py, row.px, row.idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // every 6-bit index is inside the table, so no write is dropped
        if (row.op == OP_WRITE)
        begin
            sph_x[row.idx] = row.px;
            sph_y[row.idx] = row.py;
            sph_z[row.idx] = row.pz;
            sph_r[row.idx] = row.rad;
        end
        else if (row.typed)
            push_typed(row.t_count, row.t_first);
        else
            select_nearest(row.px, row.py, row.pz);
    endtask

    // Drop valid, wait for the last result, then let a trailing write finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sel == REG_BLOCK_COUNT)
            cur_block_count = value[BCOUNT_W-1:0];
        else
            cur_select_limit = value[SLIMIT_W-1:0];
    endtask

    // Reprogram both registers on an idle block; upper data bits are noise
    task automatic configure(input int bc, input int sl);
        settle();
        write_reg(REG_BLOCK_COUNT, ($urandom() & ~32'h7F) | (bc & 32'h7F));
        write_reg(REG_SELECT_LIMIT, ($urandom() & ~32'hF) | (sl & 32'hF));
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[6:0], m_tdata[9:7], m_tdata[13:10], m_tlast};
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result beat: index %0d slot %0d count %0d last %0b",
                             $signed(got.block_index), got.slot, got.sel_count, got.last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.block_index !== want.block_index || got.slot !== want.slot ||
                    got.sel_count !== want.sel_count || got.last !== want.last)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("result mismatch: expected index %0d slot %0d count %0d last %0b, got index %0d slot %0d count %0d last %0b",
                                 $signed(want.block_index), want.slot, want.sel_count,
                                 want.last, $signed(got.block_index), got.slot,
                                 got.sel_count, got.last);
                end
            end
        end
    end

    initial
    begin
        row_t   rows[$];
        row_t   row;
        phase_t plan [N_PHASES];

        for (int i = 0; i < MAX_ENTRIES_DEF; i++)
        begin
            sph_x[i] = '0;
            sph_y[i] = '0;
            sph_z[i] = '0;
            sph_r[i] = '0;
        end
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= OP_WRITE;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items: reset values, extremes, boundaries and limit cases
        rows.insert(rows.size(), typed_query('0, '0, '0, 0, EMPTY_INDEX));
        rows.insert(rows.size(), item_row(OP_WRITE, 6'd0, '0, '0, '0, RADIUS_W'(ONE)));
        rows.insert(rows.size(), item_row(OP_WRITE, 6'd1, POS_MAX, POS_MAX, POS_MAX, R_MAX));
        rows.insert(rows.size(), item_row(OP_WRITE, 6'd2, NEG_MIN, NEG_MIN, NEG_MIN, '0));
        rows.insert(rows.size(), item_row(OP_WRITE, 6'd3, ONE, '0, '0, RADIUS_W'(ONE)));
        rows.insert(rows.size(), item_row(OP_WRITE, 6'd4, ONE, '0, '0, RADIUS_W'(ONE)));
        rows.insert(rows.size(), item_row(OP_WRITE, 6'd5, -ONE, -ONE, -ONE, R_MAX));
        rows.insert(rows.size(),
                    item_row(OP_WRITE, 6'd63, ONE, -ONE, POS_MAX, RADIUS_W'(ONE)));
        rows.insert(rows.size(), config_row(6, 8));
        rows.insert(rows.size(), query_row('0, '0, '0));
        rows.insert(rows.size(), query_row(NEG_MIN, NEG_MIN, NEG_MIN));
        rows.insert(rows.size(), query_row(POS_MAX, POS_MAX, POS_MAX));
        rows.insert(rows.size(), query_row(3 * ONE, '0, '0));
        rows.insert(rows.size(), config_row(6, 1));
        rows.insert(rows.size(), typed_query(ONE, '0, '0, 1, 7'd3));
        rows.insert(rows.size(), config_row(6, 0));
        rows.insert(rows.size(), typed_query(ONE, '0, '0, 1, 7'd3));
        rows.insert(rows.size(), config_row(6, 15));
        rows.insert(rows.size(), query_row(ONE, '0, '0));
        rows.insert(rows.size(), item_row(OP_WRITE, 6'd3, 100 * ONE, '0, '0, '0));
        rows.insert(rows.size(), query_row(ONE, '0, '0));
        rows.insert(rows.size(), query_row(3 * ONE + 1, '0, '0));

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CONFIG)
                configure(int'(rows[i].bc), int'(rows[i].sl));
            else
                send_beat(rows[i]);
        end

        // Write every entry before wider scans read them
        tx_idle_pct = 38;
        for (int i = 0; i < MAX_ENTRIES_DEF; i++)
        begin
            row     = random_row(100);
            row.idx = IDX_IN_W'(i);
            send_beat(row);
        end

        plan[0] = '{64, 8, 0, 0, 40, 1'b1};
        plan[1] = '{1, 1, 83, 0, 30, 1'b0};
        plan[2] = '{127, 15, 0, 83, 40, 1'b0};
        plan[3] = '{0, 3, 38, 38, 30, 1'b0};
        plan[4] = '{20, 5, 83, 83, 30, 1'b0};
        plan[5] = '{64, 0, 0, 0, 40, 1'b0};
        plan[6] = '{33, 8, 38, 38, 40, 1'b0};
        plan[7] = '{9, 4, 0, 83, 38, 1'b0};

        // Random phases over several settings and handshake loads
        for (int p = 0; p < N_PHASES; p++)
        begin
            configure(plan[p].bc, plan[p].sl);
            tx_idle_pct  = plan[p].tx_idle;
            rx_stall_pct = plan[p].rx_stall;
            if (plan[p].squeeze)
                long_hold_req = 1'b1;
            for (int n = 0; n < plan[p].count; n++)
                send_beat(random_row(40));
        end

        settle();
        if (errors == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
